/* design/mp3s2_pkg.sv */
// Package for the 3x3 stride-2 max pooling block.
// Holds widths, register map, reset values, the stage control struct and the signed max helper.
// No dependencies.
`default_nettype none

package mp3s2_pkg;

	localparam int PIX_W     = 8;   // signed pixel width
	localparam int SIZE_W    = 6;   // in_size register width
	localparam int CCNT_W    = 11;  // channel_count register width
	localparam int CH_W      = 10;  // channel index width
	localparam int OX_W      = 5;   // output column index width
	localparam int LB_DEPTH  = 32;  // line store entries
	localparam int PADDR_W   = 3;   // two registers at byte addresses 0 and 4
	localparam int PDATA_W   = 32;

	// Register indexes, taken from paddr[2]
	localparam logic REG_IN_SIZE  = 1'b0;
	localparam logic REG_CH_COUNT = 1'b1;

	localparam logic [SIZE_W-1:0] IN_SIZE_RST  = SIZE_W'(47);
	localparam logic [CCNT_W-1:0] CH_COUNT_RST = CCNT_W'(64);
	localparam logic [CCNT_W-1:0] CH_COUNT_MAX = CCNT_W'(1024);
	localparam logic [PIX_W-1:0]  PIX_MIN      = 8'h80;

	// Control carried alongside an item from the read stage to the write stage
	typedef struct packed {
		logic            win;        // item closes a horizontal triple of a window
		logic            row_odd;    // odd input row: merge into the line store
		logic            emit;       // item finishes a window
		logic            row_end;
		logic            channel_end;
		logic            layer_end;
		logic [OX_W-1:0] ox;
	} stage_ctrl_t;

	function automatic logic [PIX_W-1:0] max_s8(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return ($signed(a) > $signed(b)) ? a : b;
	endfunction

endpackage

`default_nettype wire

/* design/mp3s2_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Read data updates only when the read enable is high. No dependencies.
`default_nettype none

module mp3s2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/max_pool_3x3_stride2.sv */
// Top level of the 3x3 stride-2 max pooling block.
// Depends on mp3s2_pkg and the line store RAM mp3s2_ram.
//
// Use: pixels enter on the s_ stream channel, one signed int8 per item, in
// raster order, channel after channel. Each 3x3 window at stride 2 without
// padding yields one item on the m_ channel carrying the window maximum in
// m_tdata; m_tuser flags the end of an output row and of the layer, m_tlast
// the end of a channel. Output edge is (in_size-1)/2.
// Registers in_size (address 0) and channel_count (address 4) are to be written
// over the APB port while the stream is idle; the block does not enforce this.
// Latency: two register stages, the write-back stage and the output register,
// through which a window's result passes before m_tvalid rises. Throughput:
// one pixel per cycle unless a finished window waits on a stalled output, set
// by the line store, read on accept and written as the item leaves write-back.
// Reset clears counters and pipeline valids and sets previous pixels to -128;
// the line store needs no clearing since each entry is written on the first row
// of a window before it is read. When m_tready is low the output register holds
// and pixels that close no window keep flowing; once a finished window
// waits in the write-back stage behind it, s_tready drops in that cycle.
`default_nettype none

module max_pool_3x3_stride2 (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Pixel stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [mp3s2_pkg::PIX_W-1:0]    s_tdata,   // [7:0] pixel
	// Pooled stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [mp3s2_pkg::PIX_W-1:0]    m_tdata,   // [7:0] pooled
	output logic                                m_tlast,   // channel_end
	output logic      [1:0]                     m_tuser,   // [0] row_end, [1] layer_end
	// Configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mp3s2_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [mp3s2_pkg::PDATA_W-1:0]  pwdata,
	output logic      [mp3s2_pkg::PDATA_W-1:0]  prdata,
	output logic                                pready
);

	import mp3s2_pkg::*;

	// Configuration registers
	logic [SIZE_W-1:0] in_size_q;
	logic [CCNT_W-1:0] ch_count_q;
	logic              cfg_wr;

	// Position and history
	logic [SIZE_W-1:0] x_q, y_q;
	logic [CH_W-1:0]   ch_q;
	logic [PIX_W-1:0]  prev0_q, prev1_q;

	// Derived configuration
	logic [SIZE_W-1:0] edge_n;
	logic [OX_W-1:0]   out_edge;
	logic [SIZE_W-1:0] out_edge2;
	logic [CH_W-1:0]   last_ch;

	// Accept stage
	logic              accept;
	logic              x_wrap, y_wrap;
	logic              is_win;
	logic [PIX_W-1:0]  hmax;
	stage_ctrl_t       ctrl_in;

	// Write-back stage
	logic              valid_s1;
	stage_ctrl_t       ctrl_s1;
	logic [PIX_W-1:0]  hmax_s1;
	logic [PIX_W-1:0]  col_rd;
	logic [PIX_W-1:0]  merged;
	logic              adv_s1;
	logic              out_free;
	logic              lb_we;

	// Output register
	logic              out_valid_q;
	logic [PIX_W-1:0]  pooled_q;
	logic              row_end_q, channel_end_q, layer_end_q;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_size_q  <= IN_SIZE_RST;
			ch_count_q <= CH_COUNT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IN_SIZE:  in_size_q  <= pwdata[SIZE_W-1:0];
				REG_CH_COUNT: ch_count_q <= pwdata[CCNT_W-1:0];
				default:      in_size_q  <= in_size_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_IN_SIZE:  prdata = PDATA_W'(in_size_q);
			REG_CH_COUNT: prdata = PDATA_W'(ch_count_q);
			default:      prdata = '0;
		endcase
	end

	// Derive edge, output edge and last channel index
	always_comb begin
		edge_n    = (in_size_q == '0) ? SIZE_W'(1) : in_size_q;
		out_edge  = OX_W'((edge_n - SIZE_W'(1)) >> 1);
		out_edge2 = {out_edge, 1'b0};
		if (ch_count_q == '0 || ch_count_q > CH_COUNT_MAX) begin
			last_ch = '1;
		end else begin
			last_ch = CH_W'(ch_count_q - CCNT_W'(1));
		end
	end

	// Handshake: stage 1 leaves if it emits nothing or the output register is free
	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!ctrl_s1.emit || out_free);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	// Classify the incoming pixel
	always_comb begin
		hmax   = max_s8(max_s8(prev0_q, prev1_q), s_tdata);
		is_win = (x_q[SIZE_W-1:1] != '0) && !x_q[0] && (x_q <= out_edge2)
			&& (y_q <= out_edge2);
		ctrl_in.win         = is_win;
		ctrl_in.row_odd     = y_q[0];
		ctrl_in.emit        = is_win && !y_q[0] && (y_q[SIZE_W-1:1] != '0);
		ctrl_in.row_end     = (x_q[SIZE_W-1:1] == out_edge);
		ctrl_in.channel_end = ctrl_in.row_end && (y_q == out_edge2);
		ctrl_in.layer_end   = ctrl_in.channel_end && (ch_q == last_ch);
		ctrl_in.ox          = x_q[SIZE_W-1:1] - OX_W'(1);
		x_wrap = ({1'b0, x_q} + (SIZE_W+1)'(1)) >= {1'b0, edge_n};
		y_wrap = ({1'b0, y_q} + (SIZE_W+1)'(1)) >= {1'b0, edge_n};
	end

	// Advance counters and pixel history on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			ch_q    <= '0;
			prev0_q <= PIX_MIN;
			prev1_q <= PIX_MIN;
		end else if (accept) begin
			prev0_q <= prev1_q;
			prev1_q <= s_tdata;
			if (x_wrap) begin
				x_q <= '0;
				if (y_wrap) begin
					y_q  <= '0;
					ch_q <= (ch_q >= last_ch) ? '0 : ch_q + CH_W'(1);
				end else begin
					y_q <= y_q + SIZE_W'(1);
				end
			end else begin
				x_q <= x_q + SIZE_W'(1);
			end
		end
	end

	// Line store of vertical partial maxima, one entry per output column
	mp3s2_ram #(
		.WIDTH (PIX_W),
		.DEPTH (LB_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (lb_we),
		.waddr (ctrl_s1.ox),
		.wdata (ctrl_s1.row_odd ? merged : hmax_s1),
		.re    (accept && is_win),
		.raddr (ctrl_in.ox),
		.rdata (col_rd)
	);

	// Stage 1 valid and its item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_in;
			hmax_s1 <= hmax;
		end
	end

	// Merge with the stored column maximum; write back the merge on odd rows, hmax on even
	assign merged = max_s8(col_rd, hmax_s1);
	assign lb_we  = adv_s1 && ctrl_s1.win;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && ctrl_s1.emit) begin
			pooled_q      <= merged;
			row_end_q     <= ctrl_s1.row_end;
			channel_end_q <= ctrl_s1.channel_end;
			layer_end_q   <= ctrl_s1.layer_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = pooled_q;
	assign m_tlast  = channel_end_q;
	assign m_tuser  = {layer_end_q, row_end_q};

	// The line store has no forwarding: a write and a read never meet on one entry
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(lb_we && accept && is_win) |-> (ctrl_s1.ox != ctrl_in.ox))
		else $error("line store read and write hit the same entry");

	// An item may enter stage 1 only when the one there leaves
	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && valid_s1) |-> adv_s1)
		else $error("stage 1 item overwritten");

	// End flags nest: layer end implies channel end implies row end
	a_flag_nest: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((!m_tuser[1] || m_tlast) && (!m_tlast || m_tuser[0])))
		else $error("end flags out of order");

endmodule

`default_nettype wire

/* tb/max_pool_3x3_stride2_tb.sv */
// Self-checking testbench for the 3x3 stride-2 max pooling block.
// Directed table, one full-width row and random phases, scored by a local pooling predictor.
// Depends on mp3s2_pkg and max_pool_3x3_stride2.
`timescale 1ns / 1ps

module max_pool_3x3_stride2_tb;
	import mp3s2_pkg::*;

	localparam int RAND_ITEMS    = 420;
	localparam int BIG_SIZE      = 63;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS   = 10;
	localparam longint TIMEOUT_NS = 5_000_000;

	typedef struct packed {
		logic [PIX_W-1:0] pooled;
		logic             row_end;
		logic             channel_end;
		logic             layer_end;
	} pooled_t;

	// Typed expectation carried with a pixel from the directed table
	typedef struct packed {
		bit      typed;
		pooled_t want;
	} pix_note_t;

	typedef enum logic [1:0] {ROW_PIXEL, ROW_SIZE, ROW_CHANNELS} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [31:0] val;
		bit          typed;
		pooled_t     want;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [PIX_W-1:0]    s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [PIX_W-1:0]    m_tdata;
	logic                m_tlast;
	logic [1:0]          m_tuser;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Predictor state: configuration, counters, previous pixels, column maxima
	logic [SIZE_W-1:0]       size_cfg;
	logic [CCNT_W-1:0]       chan_cfg;
	int unsigned             col_pos;
	int unsigned             row_pos;
	int unsigned             chan_pos;
	logic signed [PIX_W-1:0] prev_px [2];
	logic signed [PIX_W-1:0] col_max [LB_DEPTH];

	pooled_t   pooled_q [$];
	pix_note_t note_q [$];
	plan_row_t plan [$];

	int fail_count;
	int idle_pct;
	int stall_pct;

	max_pool_3x3_stride2 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [7:0] pixel
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [7:0] pooled
		.m_tlast  (m_tlast),    // channel_end
		.m_tuser  (m_tuser),    // [0] row_end, [1] layer_end
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [PIX_W-1:0] smax8(input logic signed [PIX_W-1:0] a,
			input logic signed [PIX_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// Advance the predictor by one pixel; return 1 when a window closes
	function automatic bit pool_step(input logic signed [PIX_W-1:0] px, output pooled_t res);
		int unsigned side, span, last_ch, x, y, ox;
		logic signed [PIX_W-1:0] h;
		logic signed [PIX_W-1:0] col;
		bit made;
		made = 1'b0;
		res = '0;
		side = (size_cfg == 0) ? 1 : size_cfg;
		span = (side - 1) / 2;
		last_ch = (chan_cfg == 0 || chan_cfg > CH_COUNT_MAX) ? 1023 : chan_cfg - 1;
		x = col_pos;
		y = row_pos;
		// Close a horizontal triple on even columns inside the window grid
		if (x >= 2 && x % 2 == 0 && x <= 2 * span && y <= 2 * span) begin
			ox = x / 2 - 1;
			h = smax8(smax8(prev_px[0], prev_px[1]), px);
			col = col_max[ox];
			if (y % 2 == 0) begin
				// shared row: finish the window above, open the one below
				if (y >= 2) begin
					res.pooled = smax8(col, h);
					res.row_end = (ox + 1 == span);
					res.channel_end = res.row_end && (y == 2 * span);
					res.layer_end = res.channel_end && (chan_pos == last_ch);
					made = 1'b1;
				end
				col_max[ox] = h;
			end else begin
				col_max[ox] = smax8(col, h);
			end
		end
		prev_px[0] = prev_px[1];
		prev_px[1] = px;
		// Wrap counters at the edge, channel index at the last channel
		if (x + 1 >= side) begin
			col_pos = 0;
			if (y + 1 >= side) begin
				row_pos = 0;
				chan_pos = (chan_pos >= last_ch) ? 0 : ((chan_pos + 1) & 32'h3FF);
			end else begin
				row_pos = (y + 1) & 32'h3F;
			end
		end else begin
			col_pos = (x + 1) & 32'h3F;
		end
		return made;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return 8'h80;
		if (pick == 1) return 8'h7F;
		if (pick == 2) return PIX_W'($urandom_range(0, 3));
		return PIX_W'($urandom());
	endfunction

	// Fill unused upper bits of a register write with noise now and then
	function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
		if ($urandom_range(0, 3) == 0) return ($urandom() << w) | v;
		return v;
	endfunction

	task automatic add_row(input row_kind_e kind, input logic [31:0] val,
			input bit typed = 1'b0, input pooled_t want = '0);
		plan_row_t r;
		r.kind = kind;
		r.val = val;
		r.typed = typed;
		r.want = want;
		plan.push_back(r);
	endtask

	task automatic set_pace(input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
	endtask

	// Offer one pixel; hold valid until the item is taken
	task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed, input pooled_t want);
		pix_note_t nt;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		nt.typed = typed;
		nt.want = want;
		note_q.push_back(nt);
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid, drain every expected item, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pooled_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup and access phases, then the bus returns to idle
	task automatic write_reg(input logic sel, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_IN_SIZE) size_cfg = data[SIZE_W-1:0];
		else chan_cfg = data[CCNT_W-1:0];
		@(posedge clk);
	endtask

	task automatic report(input string what, input pooled_t want, input pooled_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("%s: expected pooled %0d row_end %0b channel_end %0b layer_end %0b",
				what, $signed(want.pooled), want.row_end, want.channel_end,
				want.layer_end);
			$display("    got pooled %0d row_end %0b channel_end %0b layer_end %0b",
				$signed(got.pooled), got.row_end, got.channel_end, got.layer_end);
		end
	endtask

	// Predict on each accepted pixel, score each accepted pooled item
	always @(posedge clk) begin
		pix_note_t nt;
		pooled_t   calc;
		pooled_t   got;
		bit        made;
		if (s_tvalid && s_tready) begin
			nt = (note_q.size() != 0) ? note_q.pop_front() : '0;
			made = pool_step(s_tdata, calc);
			if (nt.typed) pooled_q.push_back(nt.want);
			else if (made) pooled_q.push_back(calc);
		end
		if (m_tvalid && m_tready) begin
			got = {m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
			if (pooled_q.size() == 0) begin
				report("unexpected item", '0, got);
			end else begin
				calc = pooled_q.pop_front();
				if (got !== calc) report("mismatch", calc, got);
			end
		end
	end

	// Random backpressure on the pooled stream
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		#(TIMEOUT_NS);
		$display("max_pool_3x3_stride2 verification failed");
		$finish;
	end

	initial begin
		int made, npix, side, pick, sz, cnt, first, k;
		logic sel;

		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		size_cfg = IN_SIZE_RST;
		chan_cfg = CH_COUNT_RST;
		col_pos = 0;
		row_pos = 0;
		chan_pos = 0;
		prev_px[0] = PIX_MIN;
		prev_px[1] = PIX_MIN;
		foreach (col_max[i]) col_max[i] = '0;
		set_pace(16, 55);

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest full edge, two channels: floor values, then a ceiling in the corner
		add_row(ROW_SIZE, 32'd3);
		add_row(ROW_CHANNELS, 32'd2);
		for (k = 0; k < 8; k++) add_row(ROW_PIXEL, 32'h80);
		add_row(ROW_PIXEL, 32'h80, 1'b1, '{8'h80, 1'b1, 1'b1, 1'b0});
		add_row(ROW_PIXEL, 32'h7F);
		add_row(ROW_PIXEL, 32'h00);
		add_row(ROW_PIXEL, 32'h81);
		add_row(ROW_PIXEL, 32'h7E);
		add_row(ROW_PIXEL, 32'hFF);
		add_row(ROW_PIXEL, 32'h01);
		add_row(ROW_PIXEL, 32'h80);
		add_row(ROW_PIXEL, 32'h40);
		add_row(ROW_PIXEL, 32'hC0, 1'b1, '{8'h7F, 1'b1, 1'b1, 1'b1});
		// Edges too small for a window: pixels counted, nothing produced
		add_row(ROW_SIZE, 32'd2);
		add_row(ROW_PIXEL, 32'h55);
		add_row(ROW_PIXEL, 32'hAA);
		add_row(ROW_PIXEL, 32'h7F);
		add_row(ROW_PIXEL, 32'h80);
		add_row(ROW_SIZE, 32'd0);
		add_row(ROW_PIXEL, 32'h33);
		add_row(ROW_PIXEL, 32'hCC);

		for (k = 0; k < plan.size(); k++) begin
			case (plan[k].kind)
				ROW_PIXEL: begin
					send_pixel(plan[k].val[PIX_W-1:0], plan[k].typed, plan[k].want);
				end
				ROW_SIZE: begin
					settle();
					write_reg(REG_IN_SIZE, plan[k].val);
				end
				default: begin
					settle();
					write_reg(REG_CH_COUNT, plan[k].val);
				end
			endcase
		end
		settle();

		// One top row at the largest edge writes line store entries 0 to 30
		write_reg(REG_IN_SIZE, BIG_SIZE);
		write_reg(REG_CH_COUNT, 0);
		for (k = 0; k < BIG_SIZE; k++) send_pixel(rand_pixel(), 1'b0, '0);
		settle();

		// Random phases: mostly whole channels, some cut mid-channel
		made = 0;
		while (made < RAND_ITEMS) begin
			if (made < RAND_ITEMS / 3) set_pace(16, 55);
			else if (made < 2 * RAND_ITEMS / 3) set_pace(55, 16);
			else set_pace(0, 0);

			pick = $urandom_range(0, 19);
			if (pick == 0) sz = $urandom_range(0, 2);
			else if (pick == 1) sz = $urandom_range(12, 25);
			else sz = $urandom_range(3, 11);
			pick = $urandom_range(0, 9);
			if (pick == 0) cnt = 0;
			else if (pick == 1) cnt = CH_COUNT_MAX;
			else if (pick == 2) cnt = $urandom_range(1025, 2047);
			else cnt = $urandom_range(1, 4);

			first = $urandom_range(0, 1);
			for (int r = 0; r < 2; r++) begin
				sel = (r == first) ? REG_IN_SIZE : REG_CH_COUNT;
				if (sel == REG_IN_SIZE) write_reg(sel, with_junk(sz, SIZE_W));
				else write_reg(sel, with_junk(cnt, CCNT_W));
			end

			side = (sz == 0) ? 1 : sz;
			if ($urandom_range(0, 3) == 0) npix = $urandom_range(1, 2 * side * side);
			else if (side > 11) npix = side * side;
			else npix = $urandom_range(1, 3) * side * side;

			for (k = 0; k < npix; k++) send_pixel(rand_pixel(), 1'b0, '0);
			made += npix;
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pooled_q.size() == 0) begin
			$display("max_pool_3x3_stride2 verification clean");
		end else begin
			$display("max_pool_3x3_stride2 verification failed");
		end
		$finish;
	end

endmodule
